FILE: src/cfss_pkg.sv
`default_nettype none

package cfss_pkg;

    // Window depth and position counter width
    localparam int PATTERN_MAX   = 16;
    localparam int POSITION_BITS = 16;

    // Fixed field widths
    localparam int BYTE_BITS     = 8;
    localparam int LEN_BITS      = 5;
    localparam int MATCH_BITS    = 16;
    localparam int PAT_IDX_BITS  = 4;
    localparam int PAT_BITS      = 128;
    localparam int CFG_BITS      = 64;
    localparam int CFG_IDX_BITS  = 2;
    localparam int M_TDATA_BITS  = 24;

    // ASCII folding constants
    localparam logic [BYTE_BITS-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_BITS-1:0] CASE_BIT     = 8'h20;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    // Per-cycle control broadcast to every window cell
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    // Fold A-Z to lower case, leave everything else alone
    function automatic logic [BYTE_BITS-1:0] fold_byte(input logic [BYTE_BITS-1:0] c);
        logic [BYTE_BITS-1:0] r;
        r = c;
        if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/case_folding_substring_search.sv
`default_nettype none

// Case-insensitive substring search. Text bytes stream in on s_ (tlast marks
// the last byte of a string); the user must set the pattern and length (1..16,
// 0 acts as 1) via cfg while the block is idle; the block does not enforce it.
// Each string yields exactly one result beat on m_: found with the start of
// the first match once it completes, or not found after the last byte. The
// block takes one byte per cycle while m_ is not stalled; a row of window
// cells compares all pattern positions in parallel, and the result sits in a
// single output register in the cycle after the deciding byte. Positions
// saturate at 65535 and set position_overflow for the rest of that string.
module case_folding_substring_search (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // tdata: text_byte[7:0]
    input  wire  [cfss_pkg::BYTE_BITS-1:0]       s_tdata,
    input  wire                                  s_tlast,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // tdata: found[0], match_start[16:1], position_overflow[17], zero[23:18]
    output logic [cfss_pkg::M_TDATA_BITS-1:0]    m_tdata,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [cfss_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire  [cfss_pkg::CFG_BITS-1:0]        cfg_data
);
    import cfss_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam int EXT_BITS = POSITION_BITS + MATCH_BITS;
    localparam logic [EXT_BITS-1:0] START_LIMIT = EXT_BITS'({MATCH_BITS{1'b1}});

    // Configuration registers
    logic [PAT_BITS-1:0]  pattern_reg, pattern_next;
    logic [LEN_BITS-1:0]  length_reg, length_next;

    // String state
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     reported_reg, reported_next;
    logic                     overflow_reg, overflow_next;

    // Output stage
    logic                     m_valid_reg, m_valid_next;
    logic [M_TDATA_BITS-1:0]  m_data_reg, m_data_next;

    logic                     accept;
    logic                     emit;
    logic                     hit;
    logic                     long_enough;
    logic [LEN_BITS-1:0]      eff_len;
    logic [LEN_BITS-1:0]      eff_len_m1;
    logic [POSITION_BITS-1:0] start_full;
    logic [EXT_BITS-1:0]      start_ext;
    logic [MATCH_BITS-1:0]    start_sat;
    cell_ctrl_t               cell_ctrl;

    logic [BYTE_BITS-1:0]     chain [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0]   cell_match;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Clamp the configured length to 1..PATTERN_MAX
    always_comb begin
        if (length_reg == '0) begin
            eff_len = LEN_BITS'(1);
        end else if (length_reg > LEN_BITS'(PATTERN_MAX)) begin
            eff_len = LEN_BITS'(PATTERN_MAX);
        end else begin
            eff_len = length_reg;
        end
    end
    assign eff_len_m1 = eff_len - LEN_BITS'(1);

    assign cell_ctrl.clear = accept && s_tlast;
    assign cell_ctrl.shift = accept && !reported_reg;

    // Row of window cells, newest byte enters at cell 0
    assign chain[0] = fold_byte(s_tdata);

    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        logic [LEN_BITS-1:0] pat_idx;
        logic [BYTE_BITS-1:0] cell_pat;
        logic cell_in_use;

        // Cell j lines up with pattern byte (length - 1 - j)
        assign pat_idx     = eff_len_m1 - LEN_BITS'(j);
        assign cell_pat    = pattern_reg[{pat_idx[PAT_IDX_BITS-1:0], 3'b000} +: BYTE_BITS];
        assign cell_in_use = LEN_BITS'(j) < eff_len;

        cfss_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .byte_in  (chain[j]),
            .pat_byte (cell_pat),
            .in_use   (cell_in_use),
            .byte_out (chain[j+1]),
            .match    (cell_match[j])
        );
    end

    // Match decision and start position
    assign long_enough = pos_reg >= POSITION_BITS'(eff_len_m1);
    assign hit         = (&cell_match) && long_enough;
    assign start_full  = pos_reg - POSITION_BITS'(eff_len_m1);
    assign start_ext   = EXT_BITS'(start_full);
    assign start_sat   = (start_ext > START_LIMIT) ? {MATCH_BITS{1'b1}}
                                                   : start_ext[MATCH_BITS-1:0];
    assign emit        = accept && !reported_reg && (hit || s_tlast);

    // Configuration writes
    always_comb begin
        pattern_next = pattern_reg;
        length_next  = length_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:    pattern_next[CFG_BITS-1:0] = cfg_data;
                REG_PATTERN_HIGH:   pattern_next[PAT_BITS-1:CFG_BITS] = cfg_data;
                REG_PATTERN_LENGTH: length_next = cfg_data[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Position, match flag and overflow per string
    always_comb begin
        pos_next      = pos_reg;
        reported_next = reported_reg;
        overflow_next = overflow_reg;
        if (accept) begin
            priority if (s_tlast) begin
                pos_next      = '0;
                reported_next = 1'b0;
                overflow_next = 1'b0;
            end else begin
                if (emit && hit) begin
                    reported_next = 1'b1;
                end
                if (pos_reg == POS_MAX) begin
                    overflow_next = 1'b1;
                end else begin
                    pos_next = pos_reg + POSITION_BITS'(1);
                end
            end
        end
    end

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        priority if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = M_TDATA_BITS'({overflow_reg,
                                          hit ? start_sat : {MATCH_BITS{1'b0}},
                                          hit});
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg  <= '0;
            length_reg   <= LEN_BITS'(1);
            pos_reg      <= '0;
            reported_reg <= 1'b0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pattern_reg  <= pattern_next;
            length_reg   <= length_next;
            pos_reg      <= pos_next;
            reported_reg <= reported_next;
            overflow_reg <= overflow_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    // A result only loads when the output register is free or draining
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_valid_reg || m_tready))
        else $error("result loaded over a pending beat");

    // Overflow is only flagged while the position sits at its maximum
    assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> (pos_reg == POS_MAX))
        else $error("overflow flag without saturated position");

    // A last beat returns the string state to its reset values
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (pos_reg == '0) && !reported_reg && !overflow_reg)
        else $error("string state not cleared after last beat");

    // A match inside a string blocks further results until it ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && hit && !s_tlast) |=> reported_reg && m_valid_reg)
        else $error("match not recorded");
`endif

endmodule

`default_nettype wire

FILE: src/cfss_cell.sv
`default_nettype none

module cfss_cell (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  cfss_pkg::cell_ctrl_t             ctrl,
    input  wire  [cfss_pkg::BYTE_BITS-1:0]   byte_in,
    input  wire  [cfss_pkg::BYTE_BITS-1:0]   pat_byte,
    input  wire                              in_use,
    output logic [cfss_pkg::BYTE_BITS-1:0]   byte_out,
    output logic                             match
);
    import cfss_pkg::*;

    logic [BYTE_BITS-1:0] cell_byte_reg;
    logic [BYTE_BITS-1:0] cell_byte_next;

    // Compare the byte this cell takes on the current beat
    assign match    = (byte_in == pat_byte) || !in_use;
    assign byte_out = cell_byte_reg;

    // End of string clears, otherwise shift from the neighbor
    always_comb begin
        cell_byte_next = cell_byte_reg;
        priority if (ctrl.clear) begin
            cell_byte_next = '0;
        end else if (ctrl.shift) begin
            cell_byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_byte_reg <= '0;
        end else begin
            cell_byte_reg <= cell_byte_next;
        end
    end

endmodule

`default_nettype wire
